// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OGCU_ASSERT_HOLDS(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OGCU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ogcu_pkg.sv
// Types, codes and constants of the occupancy grid cell updater.
package ogcu_pkg;

    localparam int TABLE_DEPTH    = 32768;
    localparam int TABLE_AW       = 15;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int CELL_W         = 16;
    localparam int INIT_W         = 15;
    localparam int CFG_DIM_W      = 9;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int SCAN_W         = 32;

    localparam logic [2:0] ACT_HIT        = 3'd0;
    localparam logic [2:0] ACT_MISS       = 3'd1;
    localparam logic [2:0] ACT_FINISH     = 3'd2;
    localparam logic [2:0] ACT_READ       = 3'd3;
    localparam logic [2:0] ACT_LOAD_HIT   = 3'd4;
    localparam logic [2:0] ACT_LOAD_MISS  = 3'd5;
    localparam logic [2:0] ACT_CLEAR      = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE = 2'd2;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RST = 9'd256;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 9'd256;
    localparam logic [INIT_W-1:0]    INIT_RST   = 15'd16384;

    // result source
    localparam logic [2:0] RES_ZERO  = 3'd0;
    localparam logic [2:0] RES_OOB   = 3'd1;
    localparam logic [2:0] RES_CELL  = 3'd2;
    localparam logic [2:0] RES_TABLE = 3'd3;
    localparam logic [2:0] RES_INIT  = 3'd4;

    // cell write data source
    localparam logic [1:0] WR_TABLE  = 2'd0;
    localparam logic [1:0] WR_CLEAR  = 2'd1;
    localparam logic [1:0] WR_UNMARK = 2'd2;

    typedef struct packed {
        logic [2:0]          action;
        logic signed [15:0]  cell_x;
        logic signed [15:0]  cell_y;
        logic [TABLE_AW-1:0] table_index;
        logic [CELL_W-1:0]   table_value;
    } in_item_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic              was_updated;
        logic              out_of_bounds;
        logic [SCAN_W-1:0] scan_count;
    } out_item_t;

    typedef struct packed {
        logic       in_load;
        logic       calc;
        logic       addr_load;
        logic       cell_rd_en;
        logic       cell_wr_en;
        logic [1:0] wr_sel;
        logic       use_sweep;
        logic       tab_rd_en;
        logic       tab_wr_en;
        logic       sweep_clr;
        logic       sweep_inc;
        logic       scan_inc;
        logic       res_load;
        logic [2:0] res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       oob;
        logic       marked;
        logic       sweep_last;
        logic       out_free;
    } ctrl_sts_t;

endpackage

// File: sv/ogcu_ctrl.sv
// Sequencing state machine of the occupancy grid cell updater.
module ogcu_ctrl import ogcu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DEC    = 4'd1;
    localparam logic [3:0] ST_ADDR   = 4'd2;
    localparam logic [3:0] ST_CRD    = 4'd3;
    localparam logic [3:0] ST_CDAT   = 4'd4;
    localparam logic [3:0] ST_TDAT   = 4'd5;
    localparam logic [3:0] ST_RES    = 4'd6;
    localparam logic [3:0] ST_FIN_RD = 4'd7;
    localparam logic [3:0] ST_FIN_WR = 4'd8;
    localparam logic [3:0] ST_CLR    = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [2:0] res_sel_reg, res_sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            res_sel_reg <= RES_ZERO;
        end else begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.res_sel  = res_sel_reg;
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC: begin
                unique case (sts.action) inside
                    ACT_HIT, ACT_MISS, ACT_READ: begin
                        cmd.calc   = 1'b1;
                        state_next = ST_ADDR;
                    end
                    ACT_FINISH: begin
                        cmd.sweep_clr = 1'b1;
                        state_next    = ST_FIN_RD;
                    end
                    ACT_LOAD_HIT, ACT_LOAD_MISS: begin
                        cmd.tab_wr_en = 1'b1;
                        res_sel_next  = RES_ZERO;
                        state_next    = ST_RES;
                    end
                    ACT_CLEAR: begin
                        cmd.sweep_clr = 1'b1;
                        state_next    = ST_CLR;
                    end
                    default: begin
                        res_sel_next = RES_ZERO;
                        state_next   = ST_RES;
                    end
                endcase
            end
            ST_ADDR: begin
                if (sts.oob) begin
                    res_sel_next = RES_OOB;
                    state_next   = ST_RES;
                end else begin
                    cmd.addr_load = 1'b1;
                    state_next    = ST_CRD;
                end
            end
            ST_CRD: begin
                cmd.cell_rd_en = 1'b1;
                state_next     = ST_CDAT;
            end
            ST_CDAT: begin
                if (sts.action == ACT_READ || sts.marked) begin
                    res_sel_next = RES_CELL;
                    state_next   = ST_RES;
                end else begin
                    cmd.tab_rd_en = 1'b1;
                    state_next    = ST_TDAT;
                end
            end
            ST_TDAT: begin
                cmd.cell_wr_en = 1'b1;
                cmd.wr_sel     = WR_TABLE;
                res_sel_next   = RES_TABLE;
                state_next     = ST_RES;
            end
            ST_RES: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FIN_RD: begin
                cmd.use_sweep  = 1'b1;
                cmd.cell_rd_en = 1'b1;
                state_next     = ST_FIN_WR;
            end
            ST_FIN_WR: begin
                cmd.use_sweep  = 1'b1;
                cmd.cell_wr_en = 1'b1;
                cmd.wr_sel     = WR_UNMARK;
                if (sts.sweep_last) begin
                    cmd.scan_inc = 1'b1;
                    res_sel_next = RES_ZERO;
                    state_next   = ST_RES;
                end else begin
                    cmd.sweep_inc = 1'b1;
                    state_next    = ST_FIN_RD;
                end
            end
            ST_CLR: begin
                cmd.use_sweep  = 1'b1;
                cmd.cell_wr_en = 1'b1;
                cmd.wr_sel     = WR_CLEAR;
                if (sts.sweep_last) begin
                    res_sel_next = RES_INIT;
                    state_next   = ST_RES;
                end else begin
                    cmd.sweep_inc = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/ogcu_datapath.sv
// Datapath: config registers, grid and table memories, address math, result register.
module ogcu_datapath import ogcu_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ctrl_cmd_t             cmd,
    output ctrl_sts_t             sts
);

    localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int WD_W       = $clog2(MAX_WIDTH + 1);
    localparam int HD_W       = $clog2(MAX_HEIGHT + 1);

    logic [CFG_DIM_W-1:0] cfg_w_reg;
    logic [CFG_DIM_W-1:0] cfg_h_reg;
    logic [INIT_W-1:0]    init_reg;
    logic [SCAN_W-1:0]    scans_reg;

    in_item_t             in_reg;
    logic                 oob_reg;
    logic [AW-1:0]        prod_reg;
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        sweep_reg;
    logic [CELL_W-1:0]    cell_rd_reg;
    logic [CELL_W-1:0]    hit_rd_reg;
    logic [CELL_W-1:0]    miss_rd_reg;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    logic [CELL_W-1:0]    cell_mem [CELL_COUNT];
    logic [CELL_W-1:0]    hit_mem  [TABLE_DEPTH];
    logic [CELL_W-1:0]    miss_mem [TABLE_DEPTH];

    logic [WD_W-1:0]      w_eff;
    logic [HD_W-1:0]      h_eff;
    logic [15:0]          x_u;
    logic [15:0]          y_u;
    logic                 oob_c;
    logic [AW-1:0]        cell_addr;
    logic [CELL_W-1:0]    tab_data;
    logic [CELL_W-1:0]    cell_wr_data;
    out_item_t            res_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= WIDTH_RST;
            cfg_h_reg <= HEIGHT_RST;
            init_reg  <= INIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:    cfg_w_reg <= cfg_data[CFG_DIM_W-1:0];
                CFG_GRID_HEIGHT:   cfg_h_reg <= cfg_data[CFG_DIM_W-1:0];
                CFG_INITIAL_VALUE: init_reg  <= cfg_data[INIT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero reads as 1, above the maximum reads as the maximum
    always_comb begin
        if (cfg_w_reg == '0) begin
            w_eff = WD_W'(1);
        end else if (32'(cfg_w_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WD_W'(MAX_WIDTH);
        end else begin
            w_eff = WD_W'(cfg_w_reg);
        end
        if (cfg_h_reg == '0) begin
            h_eff = HD_W'(1);
        end else if (32'(cfg_h_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HD_W'(MAX_HEIGHT);
        end else begin
            h_eff = HD_W'(cfg_h_reg);
        end
    end

    // negative coordinates compare as large unsigned values
    assign x_u   = in_reg.cell_x;
    assign y_u   = in_reg.cell_y;
    assign oob_c = (x_u >= 16'(w_eff)) || (y_u >= 16'(h_eff));

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_reg <= s_data;
        end
        if (cmd.calc) begin
            oob_reg  <= oob_c;
            prod_reg <= AW'(y_u[YW-1:0]) * AW'(w_eff);
        end
        if (cmd.addr_load) begin
            addr_reg <= prod_reg + AW'(x_u[XW-1:0]);
        end
        if (cmd.sweep_clr) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_inc) begin
            sweep_reg <= sweep_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scans_reg <= '0;
        end else if (cmd.scan_inc) begin
            scans_reg <= scans_reg + SCAN_W'(1);
        end
    end

    assign cell_addr = cmd.use_sweep ? sweep_reg : addr_reg;
    assign tab_data  = (in_reg.action == ACT_MISS) ? miss_rd_reg : hit_rd_reg;

    always_comb begin
        case (cmd.wr_sel)
            WR_TABLE:  cell_wr_data = tab_data;
            WR_CLEAR:  cell_wr_data = {1'b0, init_reg};
            WR_UNMARK: cell_wr_data = {1'b0, cell_rd_reg[CELL_W-2:0]};
            default:   cell_wr_data = tab_data;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.cell_wr_en) begin
            cell_mem[cell_addr] <= cell_wr_data;
        end
        if (cmd.cell_rd_en) begin
            cell_rd_reg <= cell_mem[cell_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tab_wr_en && in_reg.action == ACT_LOAD_HIT) begin
            hit_mem[in_reg.table_index] <= in_reg.table_value;
        end
        if (cmd.tab_rd_en) begin
            hit_rd_reg <= hit_mem[cell_rd_reg[TABLE_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tab_wr_en && in_reg.action == ACT_LOAD_MISS) begin
            miss_mem[in_reg.table_index] <= in_reg.table_value;
        end
        if (cmd.tab_rd_en) begin
            miss_rd_reg <= miss_mem[cell_rd_reg[TABLE_AW-1:0]];
        end
    end

    always_comb begin
        res_c            = '0;
        res_c.scan_count = scans_reg;
        case (cmd.res_sel)
            RES_OOB:   res_c.out_of_bounds = 1'b1;
            RES_CELL:  res_c.cell_value    = cell_rd_reg;
            RES_TABLE: begin
                res_c.cell_value  = tab_data;
                res_c.was_updated = 1'b1;
            end
            RES_INIT:  res_c.cell_value    = {1'b0, init_reg};
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            out_data_reg <= res_c;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign sts.action     = in_reg.action;
    assign sts.oob        = oob_reg;
    assign sts.marked     = cell_rd_reg[CELL_W-1];
    assign sts.sweep_last = (sweep_reg == AW'(CELL_COUNT - 1));
    assign sts.out_free   = !out_valid_reg || m_ready;

endmodule

// File: sv/occupancy_grid_cell_update.sv
// One transaction at a time: the next accept comes in the cycle after the result loads, and a
// stalled result holds the controller in its result state. Finish reads then writes each of
// the MAX_WIDTH*MAX_HEIGHT cells in turn, clear writes one cell a cycle; both run on the single
// grid memory port.
// Synchronous active-low reset clears control, config and scan count; memories stay undefined.
`include "assert_macros.svh"
module occupancy_grid_cell_update import ogcu_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    ogcu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ogcu_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    `OGCU_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "second transaction accepted while busy")
    `OGCU_ASSERT_HOLDS(a_no_result_overwrite, aclk, aresetn, cmd.res_load, sts.out_free, "result register overwritten")
    `OGCU_ASSERT_HOLDS(a_single_grid_port, aclk, aresetn, cmd.cell_wr_en, !cmd.cell_rd_en, "grid read and write in one cycle")
    `OGCU_ASSERT_HOLDS(a_flags_exclusive, aclk, aresetn, m_valid, !(m_data.was_updated && m_data.out_of_bounds), "updated and out of bounds together")

endmodule

// File: bench/cell_update_checker.sv
// Checker for the occupancy grid cell updater: predicts each result and compares it.
`timescale 1ns / 100ps
module cell_update_checker import ogcu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    open_count
);

    localparam int CELL_COUNT = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    logic [CELL_W-1:0]    grid_cells [CELL_COUNT];
    logic [CELL_W-1:0]    hit_lut    [TABLE_DEPTH];
    logic [CELL_W-1:0]    miss_lut   [TABLE_DEPTH];
    logic [SCAN_W-1:0]    scan_total;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [INIT_W-1:0]    init_reg;

    out_item_t due_cell_results [$];

    initial begin
        error_count = 0;
        open_count  = 0;
    end

    function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] raw, input int limit);
        if (raw == 0)
            return 1;
        if (int'(raw) > limit)
            return limit;
        return int'(raw);
    endfunction

    function automatic out_item_t compute_cell_result(input in_item_t it);
        out_item_t   r;
        int          w, h, cx, cy, idx, i;
        logic [15:0] cur;
        r  = '0;
        w  = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h  = clamp_dim(height_reg, DEF_MAX_HEIGHT);
        cx = int'(it.cell_x);
        cy = int'(it.cell_y);
        case (it.action)
            ACT_HIT, ACT_MISS, ACT_READ: begin
                if (cx < 0 || cy < 0 || cx >= w || cy >= h) begin
                    r.out_of_bounds = 1'b1;
                end else begin
                    idx = cy * w + cx;
                    cur = grid_cells[idx];
                    if (it.action != ACT_READ && !cur[15]) begin
                        cur = (it.action == ACT_HIT) ? hit_lut[cur[14:0]] : miss_lut[cur[14:0]];
                        grid_cells[idx] = cur;
                        r.was_updated = 1'b1;
                    end
                    r.cell_value = cur;
                end
            end
            ACT_FINISH: begin
                scan_total = scan_total + 1;
                for (i = 0; i < CELL_COUNT; i++)
                    grid_cells[i][15] = 1'b0;
            end
            ACT_LOAD_HIT: hit_lut[it.table_index] = it.table_value;
            ACT_LOAD_MISS: miss_lut[it.table_index] = it.table_value;
            ACT_CLEAR: begin
                for (i = 0; i < CELL_COUNT; i++)
                    grid_cells[i] = {1'b0, init_reg};
                r.cell_value = {1'b0, init_reg};
            end
            default: ;
        endcase
        r.scan_count = scan_total;
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            init_reg   = INIT_RST;
            scan_total = '0;
            due_cell_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GRID_WIDTH:    width_reg  = cfg_data[CFG_DIM_W-1:0];
                    CFG_GRID_HEIGHT:   height_reg = cfg_data[CFG_DIM_W-1:0];
                    CFG_INITIAL_VALUE: init_reg   = cfg_data[INIT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (due_cell_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, m_data);
                    error_count++;
                end else begin
                    want = due_cell_results.pop_front();
                    compare_field("cell_value", 32'(want.cell_value),
                                  32'(m_data.cell_value));
                    compare_field("was_updated", 32'(want.was_updated),
                                  32'(m_data.was_updated));
                    compare_field("out_of_bounds", 32'(want.out_of_bounds),
                                  32'(m_data.out_of_bounds));
                    compare_field("scan_count", want.scan_count, m_data.scan_count);
                end
            end
            if (s_valid && s_ready)
                due_cell_results.insert(due_cell_results.size(), compute_cell_result(s_data));
        end
        open_count = due_cell_results.size();
    end

endmodule

// File: bench/tb_occupancy_grid_cell_update.sv
// Stimulus, clocking and verdict for the occupancy grid cell updater.
`timescale 1ns / 100ps
module tb_occupancy_grid_cell_update;
    import ogcu_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int KEY_COUNT   = 6;
    localparam int PHASE_ITEMS = 200;
    localparam logic [2:0]           ACT_SPARE = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   error_count, open_count;
    int   sent_cnt  = 0;
    int   got_cnt   = 0;
    int   cycle_cnt = 0;
    int   hold_cnt  = 0;
    logic idle_on   = 1'b0;

    // table entries that are always loaded; every cell value's low bits stay among them
    logic [14:0] lut_keys [KEY_COUNT];
    int          eff_w, eff_h;
    logic [15:0] recent_x [8];
    logic [15:0] recent_y [8];
    int          recent_n;

    occupancy_grid_cell_update uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cell_update_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .error_count(error_count), .open_count(open_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("tb_occupancy_grid_cell_update: done, errors");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sent_cnt <= sent_cnt + 1;
            if (m_valid && m_ready)
                got_cnt <= got_cnt + 1;
        end
    end

    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold_cnt <= $urandom_range(0, 10);
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] raw, input int limit);
        if (raw == 0)
            return 1;
        if (int'(raw) > limit)
            return limit;
        return int'(raw);
    endfunction

    function automatic in_item_t make_item(input logic [2:0] act, input logic [15:0] x,
                                           input logic [15:0] y, input logic [14:0] idx,
                                           input logic [15:0] val);
        in_item_t it;
        it.action      = act;
        it.cell_x      = x;
        it.cell_y      = y;
        it.table_index = idx;
        it.table_value = val;
        return it;
    endfunction

    function automatic logic [15:0] safe_entry();
        logic mark;
        mark = ($urandom_range(0, 3) != 0);
        return {mark, lut_keys[$urandom_range(0, KEY_COUNT - 1)]};
    endfunction

    function automatic bit is_key(input logic [14:0] idx);
        int i;
        for (i = 0; i < KEY_COUNT; i++)
            if (lut_keys[i] == idx)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick, sel, slot;
        it.cell_x      = 16'($urandom);
        it.cell_y      = 16'($urandom);
        it.table_index = 15'($urandom);
        it.table_value = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 36)      it.action = ACT_HIT;
        else if (pick < 60) it.action = ACT_MISS;
        else if (pick < 74) it.action = ACT_READ;
        else if (pick < 86) it.action = ACT_LOAD_HIT;
        else if (pick < 98) it.action = ACT_LOAD_MISS;
        else                it.action = ACT_SPARE;
        if (it.action == ACT_LOAD_HIT || it.action == ACT_LOAD_MISS) begin
            if ($urandom_range(0, 1) == 0)
                it.table_index = lut_keys[$urandom_range(0, KEY_COUNT - 1)];
            if (is_key(it.table_index))
                it.table_value = safe_entry();
        end else if (it.action != ACT_SPARE) begin
            sel = $urandom_range(0, 99);
            if (sel < 55 && recent_n > 0) begin
                slot = $urandom_range(0, recent_n - 1);
                it.cell_x = recent_x[slot];
                it.cell_y = recent_y[slot];
            end else if (sel < 85) begin
                it.cell_x = 16'($urandom_range(0, eff_w - 1));
                it.cell_y = 16'($urandom_range(0, eff_h - 1));
                slot = (recent_n < 8) ? recent_n : $urandom_range(0, 7);
                recent_x[slot] = it.cell_x;
                recent_y[slot] = it.cell_y;
                if (recent_n < 8)
                    recent_n++;
            end else begin
                it.cell_x = 16'($urandom_range(0, eff_w - 1));
                it.cell_y = 16'($urandom_range(0, eff_h - 1));
                case ($urandom_range(0, 5))
                    0: it.cell_x = 16'($urandom_range(32768, 65535));
                    1: it.cell_y = 16'($urandom_range(32768, 65535));
                    2: it.cell_x = 16'(eff_w);
                    3: it.cell_y = 16'(eff_h);
                    4: it.cell_x = 16'($urandom_range(eff_w, 32767));
                    default: begin
                        it.cell_x = 16'($urandom);
                        it.cell_y = 16'($urandom);
                    end
                endcase
            end
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (got_cnt != sent_cnt) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_grid(input logic [8:0] w_raw, input logic [8:0] h_raw,
                            input logic [14:0] init);
        logic [6:0] noise_w, noise_h;
        logic       noise_i;
        noise_w = 7'($urandom);
        noise_h = 7'($urandom);
        noise_i = 1'($urandom);
        write_reg(CFG_GRID_WIDTH, {noise_w, w_raw});
        write_reg(CFG_GRID_HEIGHT, {noise_h, h_raw});
        write_reg(CFG_INITIAL_VALUE, {noise_i, init});
        eff_w    = clamp_dim(w_raw, DEF_MAX_WIDTH);
        eff_h    = clamp_dim(h_raw, DEF_MAX_HEIGHT);
        recent_n = 0;
    endtask

    initial begin
        int          i, ph, n, sweep_at;
        logic [15:0] hv, mv;
        logic [8:0]  w_raw, h_raw;
        logic [14:0] init;

        lut_keys[0] = 15'd0;
        lut_keys[1] = 15'd1;
        lut_keys[2] = 15'd16384;
        lut_keys[3] = 15'd32767;
        lut_keys[4] = 15'($urandom_range(2, 32766));
        lut_keys[5] = 15'($urandom_range(2, 32766));
        recent_n = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_grid(9'd3, 9'd2, 15'd32767);
        write_reg(CFG_SPARE, 16'($urandom));

        for (i = 0; i < KEY_COUNT; i++) begin
            hv = safe_entry();
            mv = safe_entry();
            if (lut_keys[i] == 15'd0)
                hv = 16'hFFFF;
            if (lut_keys[i] == 15'd32767)
                hv = 16'h8000;
            if (lut_keys[i] == 15'd1) begin
                hv = {1'b0, 15'd16384};
                mv = 16'h0000;
            end
            send_item(make_item(ACT_LOAD_HIT, 16'($urandom), 16'($urandom), lut_keys[i], hv));
            send_item(make_item(ACT_LOAD_MISS, 16'($urandom), 16'($urandom), lut_keys[i], mv));
        end
        send_item(make_item(ACT_CLEAR, 16'($urandom), 16'($urandom), 15'($urandom),
                            16'($urandom)));
        send_item(make_item(ACT_READ, 16'd0, 16'd0, 15'($urandom), 16'($urandom)));
        // cell goes to the bare mark, then a second hit finds it marked
        send_item(make_item(ACT_HIT, 16'd0, 16'd0, 15'($urandom), 16'($urandom)));
        send_item(make_item(ACT_HIT, 16'd0, 16'd0, 15'($urandom), 16'($urandom)));
        send_item(make_item(ACT_MISS, 16'd2, 16'd1, 15'($urandom), 16'($urandom)));
        send_item(make_item(ACT_HIT, 16'hFFFF, 16'd0, 15'($urandom), 16'($urandom)));
        send_item(make_item(ACT_HIT, 16'd3, 16'd1, 15'($urandom), 16'($urandom)));
        send_item(make_item(ACT_MISS, 16'd1, 16'd2, 15'($urandom), 16'($urandom)));
        send_item(make_item(ACT_READ, 16'h8000, 16'h7FFF, 15'($urandom), 16'($urandom)));
        send_item(make_item(ACT_FINISH, 16'($urandom), 16'($urandom), 15'($urandom),
                            16'($urandom)));
        send_item(make_item(ACT_READ, 16'd0, 16'd0, 15'($urandom), 16'($urandom)));
        send_item(make_item(ACT_HIT, 16'd0, 16'd0, 15'($urandom), 16'($urandom)));
        send_item(make_item(ACT_SPARE, 16'($urandom), 16'($urandom), 15'($urandom),
                            16'($urandom)));

        for (ph = 0; ph < 6; ph++) begin
            wait_drained();
            init = lut_keys[$urandom_range(1, KEY_COUNT - 1)];
            case (ph)
                0: begin w_raw = 9'd256; h_raw = 9'd256; end
                1: begin w_raw = 9'd1;   h_raw = 9'd1; init = 15'd1; end
                2: begin w_raw = 9'd511; h_raw = 9'd0; end
                3: begin
                    w_raw = 9'($urandom_range(1, 16));
                    h_raw = 9'($urandom_range(1, 16));
                    init  = 15'd16384;
                end
                4: begin
                    w_raw = 9'($urandom_range(0, 511));
                    h_raw = 9'($urandom_range(0, 511));
                end
                default: begin
                    w_raw = 9'($urandom_range(2, 8));
                    h_raw = 9'($urandom_range(2, 8));
                end
            endcase
            set_grid(w_raw, h_raw, init);
            sweep_at = $urandom_range(20, PHASE_ITEMS - 20);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0)
                    idle_on <= (ph != 5) && ($urandom_range(0, 9) < 7);
                if (n == sweep_at && (ph == 1 || ph == 3))
                    send_item(make_item(ACT_CLEAR, 16'($urandom), 16'($urandom),
                                        15'($urandom), 16'($urandom)));
                else if (n == sweep_at && (ph == 2 || ph == 4))
                    send_item(make_item(ACT_FINISH, 16'($urandom), 16'($urandom),
                                        15'($urandom), 16'($urandom)));
                else
                    send_item(random_item());
            end
        end

        wait_drained();
        repeat (16) @(posedge aclk);
        if (error_count == 0 && open_count == 0)
            $display("tb_occupancy_grid_cell_update: done, clean");
        else
            $display("tb_occupancy_grid_cell_update: done, errors");
        $finish;
    end

endmodule
